FILE: sv/scanline_line_position_top_assert.svh
// Assertion macros for the scanline line position modules.
// Depends on nothing; define NO_ASSERTIONS to compile every check away.
`ifndef SCANLINE_LINE_POSITION_TOP_ASSERT_SVH
`define SCANLINE_LINE_POSITION_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset only
`define SLP_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication, checked out of reset only
`define SLP_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define SLP_ASSERT_IMP(lbl, pre, post)
`define SLP_ASSERT_NXT(lbl, pre, post)
`endif
`endif

FILE: sv/slp_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// scanline line position block. Depends on nothing.
`default_nettype none
package slp_pkg;

    // Row geometry
    localparam int MAX_ROW_WIDTH = 1024;
    localparam int IDX_W = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
    localparam int CNT_W = $clog2(MAX_ROW_WIDTH + 2);

    // Position arithmetic: mean quotient stays below 200
    localparam int POS_SCALE = 100;
    localparam int QUO_W = 8;
    localparam int BIT_W = $clog2(QUO_W);
    localparam int SUM_W = $clog2(2 * POS_SCALE * MAX_ROW_WIDTH);
    localparam int REM_W = CNT_W + QUO_W;

    localparam logic [7:0] THRESH_RESET = 8'd50;
    localparam logic signed [7:0] POS_NONE  = 8'sd0;
    localparam logic signed [7:0] POS_LEFT  = -8'sd100;
    localparam logic signed [7:0] POS_RIGHT = 8'sd100;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_LEFT  = 2'd1,
        KIND_RIGHT = 2'd2,
        KIND_MEAN  = 2'd3
    } kind_t;

    typedef struct packed {
        logic             accum;
        logic             row_load;
        logic             div_step;
        logic [BIT_W-1:0] div_bit;
        logic             out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic row_mean;
    } dp_status_t;

endpackage
`default_nettype wire

FILE: sv/slp_ctrl.sv
// Controller for the scanline line position block: pixel intake, the
// row-end division sequence and the output valid. Uses slp_pkg.
`default_nettype none
`include "scanline_line_position_top_assert.svh"
module slp_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               row_end,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire slp_pkg::dp_status_t status,
    output slp_pkg::dp_cmd_t        cmd
);

    typedef enum logic [1:0] {
        S_ACCUM,
        S_DIV,
        S_PUSH
    } state_t;

    state_t                    state_reg, state_next;
    logic [slp_pkg::BIT_W-1:0] bit_reg, bit_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      in_accept;
    logic                      slot_free;

    // Accept pixels only while accumulating
    assign in_ready  = (state_reg == S_ACCUM);
    assign in_accept = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // Drive datapath commands
    always_comb
    begin
        cmd          = '0;
        cmd.accum    = in_accept;
        cmd.row_load = in_accept && row_end;
        cmd.div_step = (state_reg == S_DIV);
        cmd.div_bit  = bit_reg;
        cmd.out_load = (state_reg == S_PUSH) && slot_free;
    end

    // Next state and registered outputs
    always_comb
    begin
        state_next     = state_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_ACCUM:
            begin
                if (in_accept && row_end)
                begin
                    if (status.row_mean)
                    begin
                        state_next = S_DIV;
                        bit_next   = slp_pkg::BIT_W'(slp_pkg::QUO_W - 1);
                    end
                    else
                    begin
                        state_next = S_PUSH;
                    end
                end
            end
            S_DIV:
            begin
                if (bit_reg == '0)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            S_PUSH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_ACCUM;
                end
            end
            default:
            begin
                state_next = S_ACCUM;
            end
        endcase
    end

    // Hold state, bit counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACCUM;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `SLP_ASSERT_NXT(a_mean_divides, in_accept && row_end && status.row_mean, state_reg == S_DIV)
    `SLP_ASSERT_NXT(a_edge_pushes, in_accept && row_end && !status.row_mean, state_reg == S_PUSH)
    `SLP_ASSERT_NXT(a_div_ends, state_reg == S_DIV && bit_reg == '0, state_reg == S_PUSH)
    `SLP_ASSERT_NXT(a_load_shows, cmd.out_load, out_valid_reg && state_reg == S_ACCUM)

endmodule
`default_nettype wire

FILE: sv/slp_dpath.sv
// Datapath for the scanline line position block: threshold register, row
// accumulators, restoring divider and output payload. Uses slp_pkg.
`default_nettype none
module slp_dpath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [7:0]         cfg_data,
    input  wire logic [7:0]         gray_pixel,
    input  wire logic               row_end,
    input  wire slp_pkg::dp_cmd_t   cmd,
    output slp_pkg::dp_status_t     status,
    output logic signed [7:0]       line_position,
    output logic [1:0]              detect_kind
);

    logic [7:0]                thresh_reg;
    logic [slp_pkg::CNT_W-1:0] cnt_reg;
    logic                      saw_black_reg, saw_white_reg, first_black_reg;
    logic [slp_pkg::IDX_W-1:0] first_idx_reg, last_idx_reg;

    logic [slp_pkg::CNT_W-1:0] cnt_next;
    logic                      saw_black_next, saw_white_next, first_black_next;
    logic [slp_pkg::IDX_W-1:0] first_idx_next, last_idx_next;
    logic                      is_black, is_white, in_range;
    slp_pkg::kind_t            kind_now;
    logic [slp_pkg::IDX_W:0]   pair_sum;
    logic [slp_pkg::SUM_W-1:0] scaled_sum;

    slp_pkg::kind_t            kind_reg;
    logic [slp_pkg::REM_W-1:0] rem_reg;
    logic [slp_pkg::CNT_W-1:0] div_reg;
    logic [slp_pkg::QUO_W-1:0] quo_reg;
    logic [slp_pkg::REM_W-1:0] trial;
    logic                      fits;
    logic [slp_pkg::QUO_W:0]   mean_diff;

    logic signed [7:0]         pos_reg;
    slp_pkg::kind_t            out_kind_reg;
    logic signed [7:0]         pos_sel;

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= slp_pkg::THRESH_RESET;
        end
        else if (cfg_write)
        begin
            thresh_reg <= cfg_data;
        end
    end

    // Classify the pixel and update row statistics
    always_comb
    begin
        is_black         = gray_pixel < thresh_reg;
        is_white         = gray_pixel > thresh_reg;
        in_range         = cnt_reg < slp_pkg::CNT_W'(slp_pkg::MAX_ROW_WIDTH);
        saw_black_next   = saw_black_reg || is_black;
        saw_white_next   = saw_white_reg || is_white;
        first_black_next = first_black_reg;
        first_idx_next   = first_idx_reg;
        last_idx_next    = last_idx_reg;
        cnt_next         = cnt_reg;
        if (in_range)
        begin
            if (cnt_reg == '0)
            begin
                first_black_next = is_black;
            end
            if (is_black)
            begin
                if (!saw_black_reg)
                begin
                    first_idx_next = cnt_reg[slp_pkg::IDX_W-1:0];
                end
                last_idx_next = cnt_reg[slp_pkg::IDX_W-1:0];
            end
        end
        if (cnt_reg <= slp_pkg::CNT_W'(slp_pkg::MAX_ROW_WIDTH))
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        // Decide the row's kind in priority order
        if (cnt_next > slp_pkg::CNT_W'(slp_pkg::MAX_ROW_WIDTH)
            || !saw_black_next || !saw_white_next)
        begin
            kind_now = slp_pkg::KIND_NONE;
        end
        else if (first_black_next)
        begin
            kind_now = slp_pkg::KIND_LEFT;
        end
        else if (is_black)
        begin
            kind_now = slp_pkg::KIND_RIGHT;
        end
        else
        begin
            kind_now = slp_pkg::KIND_MEAN;
        end
        pair_sum   = {1'b0, first_idx_next} + {1'b0, last_idx_next};
        scaled_sum = slp_pkg::SUM_W'(pair_sum) * slp_pkg::SUM_W'(slp_pkg::POS_SCALE);
    end

    assign status.row_mean = (kind_now == slp_pkg::KIND_MEAN);

    // Advance row accumulators; clear at row end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg         <= '0;
            saw_black_reg   <= 1'b0;
            saw_white_reg   <= 1'b0;
            first_black_reg <= 1'b0;
            first_idx_reg   <= '0;
            last_idx_reg    <= '0;
        end
        else if (cmd.accum)
        begin
            if (row_end)
            begin
                cnt_reg         <= '0;
                saw_black_reg   <= 1'b0;
                saw_white_reg   <= 1'b0;
                first_black_reg <= 1'b0;
                first_idx_reg   <= '0;
                last_idx_reg    <= '0;
            end
            else
            begin
                cnt_reg         <= cnt_next;
                saw_black_reg   <= saw_black_next;
                saw_white_reg   <= saw_white_next;
                first_black_reg <= first_black_next;
                first_idx_reg   <= first_idx_next;
                last_idx_reg    <= last_idx_next;
            end
        end
    end

    // One restoring division step, quotient bit from the top down
    assign trial = slp_pkg::REM_W'(div_reg) << cmd.div_bit;
    assign fits  = rem_reg >= trial;

    // Snapshot the row, then iterate the divider
    always_ff @(posedge clk)
    begin
        if (cmd.row_load)
        begin
            kind_reg <= kind_now;
            rem_reg  <= slp_pkg::REM_W'(scaled_sum);
            div_reg  <= cnt_next;
            quo_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - trial;
            end
            quo_reg <= {quo_reg[slp_pkg::QUO_W-2:0], fits};
        end
    end

    // Select the position for the row's kind
    assign mean_diff = {1'b0, quo_reg} - (slp_pkg::QUO_W + 1)'(slp_pkg::POS_SCALE);

    always_comb
    begin
        case (kind_reg)
            slp_pkg::KIND_NONE:  pos_sel = slp_pkg::POS_NONE;
            slp_pkg::KIND_LEFT:  pos_sel = slp_pkg::POS_LEFT;
            slp_pkg::KIND_RIGHT: pos_sel = slp_pkg::POS_RIGHT;
            slp_pkg::KIND_MEAN:  pos_sel = $signed(mean_diff[7:0]);
            default:             pos_sel = slp_pkg::POS_NONE;
        endcase
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            pos_reg      <= pos_sel;
            out_kind_reg <= kind_reg;
        end
    end

    assign line_position = pos_reg;
    assign detect_kind   = out_kind_reg;

endmodule
`default_nettype wire

FILE: sv/scanline_line_position_top.sv
// Pixels are taken one per cycle while accumulating. Edge and undetermined rows go
// from the row-end pixel to the push state; interior-mean rows first pass the
// 8-step restoring divider. No pixel is taken until the result is loaded.
// A waiting result does not stop pixel intake of the next row.
// Reset (rst_n low, asynchronous) clears the row state and the output valid
// and sets the threshold to 50.
// Top level of the scanline line position block; joins slp_ctrl and
// slp_dpath. Uses slp_pkg.
`default_nettype none
module scanline_line_position_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  gray_pixel,
    input  wire logic        row_end,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic signed [7:0] line_position,
    output logic [1:0]       detect_kind
);

    slp_pkg::dp_cmd_t    cmd;
    slp_pkg::dp_status_t status;

    // Threshold writes always complete in one transaction
    assign cfg_ready = 1'b1;

    slp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .row_end   (row_end),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    slp_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .gray_pixel    (gray_pixel),
        .row_end       (row_end),
        .cmd           (cmd),
        .status        (status),
        .line_position (line_position),
        .detect_kind   (detect_kind)
    );

endmodule
`default_nettype wire
